// ===== rtl/core/dltq_pkg.sv =====
// Shared types and constants for the delta list timer queue.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
`default_nettype none

package dltq_pkg;

  localparam int IDX_W      = 4;
  localparam int NUM_TIMERS = 1 << IDX_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int MAX_RESULTS = 16;
  localparam int DELTA_W    = 32;
  localparam int DELAY_W    = 31;
  localparam int PERIOD_W   = 16;
  localparam int TIME_W     = 32;
  // Wide enough for a running sum of NUM_TIMERS deltas plus a new delay.
  localparam int ACC_W      = DELTA_W + IDX_W + 1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_CANCEL = 2'd2,
    OP_POLL   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_RUNNING = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_LOAD,
    S_REMOVE,
    S_WALK,
    S_LINK,
    S_SPLIT,
    S_APPEND
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    new_handle;
    logic                expired_valid;
    logic [IDX_W-1:0]    expired_handle;
    logic [TIME_W-1:0]   free_count;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dltq_sat_add.sv =====
// Shared adder of the timer queue: one wide signed add with saturation to 32 bits.
// Depends on dltq_pkg for the accumulator type.
`default_nettype none

module dltq_sat_add (
  input  wire dltq_pkg::acc_t   a,
  input  wire dltq_pkg::acc_t   b,
  output dltq_pkg::acc_t        sum,
  output dltq_pkg::delta_t      sat
);

  localparam dltq_pkg::acc_t ACC_MAX =
    {{(dltq_pkg::ACC_W-dltq_pkg::DELTA_W+1){1'b0}}, {(dltq_pkg::DELTA_W-1){1'b1}}};
  localparam dltq_pkg::acc_t ACC_MIN =
    {{(dltq_pkg::ACC_W-dltq_pkg::DELTA_W+1){1'b1}}, {(dltq_pkg::DELTA_W-1){1'b0}}};

  assign sum = a + b;

  // Clamp to the signed 32-bit range.
  always_comb begin
    if (sum > ACC_MAX) begin
      sat = ACC_MAX[dltq_pkg::DELTA_W-1:0];
    end else if (sum < ACC_MIN) begin
      sat = ACC_MIN[dltq_pkg::DELTA_W-1:0];
    end else begin
      sat = sum[dltq_pkg::DELTA_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dltq_seq.sv =====
// Sequencer of the timer queue: entry stores, list pointers and the state machine
// that walks the delta list one entry per cycle. Depends on dltq_pkg and dltq_sat_add.
`default_nettype none

module dltq_seq (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [1:0]                       op,
  input  wire  [dltq_pkg::DELAY_W-1:0]     delay_ms,
  input  wire  [dltq_pkg::IDX_W-1:0]       handle,
  input  wire  [dltq_pkg::PERIOD_W-1:0]    period,
  input  wire                              slot_free,
  output logic                             res_push,
  output dltq_pkg::res_t                   res
);

  localparam int IW = dltq_pkg::IDX_W;
  localparam int CW = dltq_pkg::CNT_W;
  localparam int AW = dltq_pkg::ACC_W;
  localparam int DW = dltq_pkg::DELTA_W;
  localparam logic [CW-1:0] LAST_K = CW'(dltq_pkg::MAX_RESULTS - 1);

  function automatic dltq_pkg::acc_t sext_delta(input dltq_pkg::delta_t v);
    return {{(AW-DW){v[DW-1]}}, v};
  endfunction

  // Entry stores
  dltq_pkg::delta_t delta_mem [dltq_pkg::NUM_TIMERS];
  logic [IW-1:0]    next_mem  [dltq_pkg::NUM_TIMERS];
  logic [IW-1:0]    prev_mem  [dltq_pkg::NUM_TIMERS];
  logic [dltq_pkg::NUM_TIMERS-1:0] running;

  // Control registers
  dltq_pkg::state_t state, state_next;
  logic [IW-1:0]    head, head_next;
  logic [IW-1:0]    tail, tail_next;
  logic [CW-1:0]    count, count_next;
  logic [dltq_pkg::TIME_W-1:0] time_counter, time_next;

  // Per-item working registers
  dltq_pkg::op_t    op_reg;
  logic [dltq_pkg::DELAY_W-1:0] t_reg;
  logic [IW-1:0]    e_reg, n_reg, p_reg, pos, nw;
  dltq_pkg::delta_t d_cur;
  dltq_pkg::acc_t   absum, prev_absum;
  logic [CW-1:0]    walk_i, k;
  logic             full;

  // Read port and shared unit
  logic [IW-1:0]    rd_addr;
  dltq_pkg::delta_t delta_rd;
  logic [IW-1:0]    next_rd, prev_rd;
  dltq_pkg::acc_t   unit_a, unit_b, unit_sum;
  dltq_pkg::delta_t unit_sat;
  dltq_pkg::acc_t   t_ext;

  // Write controls
  logic             delta_we, next_we, prev_we;
  logic [IW-1:0]    delta_wa, next_wa, prev_wa;
  logic [IW-1:0]    next_wd, prev_wd;
  logic             run_set, run_clr;
  logic [IW-1:0]    run_idx;

  logic             accept, load_ok, load_latch, walk_step, walk_hit, poll_more;
  logic             has_next, has_prev;
  logic [IW-1:0]    free_idx;

  assign accept   = in_valid && in_ready;
  assign delta_rd = delta_mem[rd_addr];
  assign next_rd  = next_mem[rd_addr];
  assign prev_rd  = prev_mem[rd_addr];
  assign t_ext    = {{(AW-dltq_pkg::DELAY_W){1'b0}}, t_reg};
  assign has_next = (e_reg != tail);
  assign has_prev = (e_reg != head);
  assign walk_hit = (t_ext < unit_sum);

  dltq_sat_add u_add (
    .a   (unit_a),
    .b   (unit_b),
    .sum (unit_sum),
    .sat (unit_sat)
  );

  // Lowest-numbered free entry
  always_comb begin
    free_idx = '0;
    for (int i = dltq_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
      if (!running[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    load_ok = (op_reg == dltq_pkg::OP_CANCEL) ? running[e_reg]
                                              : ((count != '0) && (delta_rd <= 0));
    poll_more = (op_reg == dltq_pkg::OP_POLL) && has_next && (unit_sat <= 0) &&
                (k != LAST_K);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      dltq_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (dltq_pkg::op_t'(op))
            dltq_pkg::OP_TICK:   state_next = dltq_pkg::S_TICK;
            dltq_pkg::OP_CREATE: state_next = dltq_pkg::S_WALK;
            dltq_pkg::OP_CANCEL,
            dltq_pkg::OP_POLL:   state_next = dltq_pkg::S_LOAD;
            default:             state_next = dltq_pkg::S_IDLE;
          endcase
        end
      end
      dltq_pkg::S_TICK: begin
        if (slot_free) state_next = dltq_pkg::S_IDLE;
      end
      dltq_pkg::S_LOAD: begin
        if (load_ok) begin
          state_next = dltq_pkg::S_REMOVE;
        end else if (slot_free) begin
          state_next = dltq_pkg::S_IDLE;
        end
      end
      dltq_pkg::S_REMOVE: begin
        if (slot_free) state_next = poll_more ? dltq_pkg::S_LOAD : dltq_pkg::S_IDLE;
      end
      dltq_pkg::S_WALK: begin
        if (full) begin
          if (slot_free) state_next = dltq_pkg::S_IDLE;
        end else if (walk_i == count) begin
          state_next = dltq_pkg::S_APPEND;
        end else if (walk_hit) begin
          state_next = dltq_pkg::S_LINK;
        end
      end
      dltq_pkg::S_LINK:   state_next = dltq_pkg::S_SPLIT;
      dltq_pkg::S_SPLIT,
      dltq_pkg::S_APPEND: begin
        if (slot_free) state_next = dltq_pkg::S_IDLE;
      end
      default: state_next = dltq_pkg::S_IDLE;
    endcase
  end

  // Datapath controls and result word
  always_comb begin
    in_ready   = 1'b0;
    rd_addr    = e_reg;
    unit_a     = sext_delta(delta_rd);
    unit_b     = sext_delta(d_cur);
    delta_we   = 1'b0;
    delta_wa   = e_reg;
    next_we    = 1'b0;
    next_wa    = e_reg;
    next_wd    = e_reg;
    prev_we    = 1'b0;
    prev_wa    = e_reg;
    prev_wd    = e_reg;
    run_set    = 1'b0;
    run_clr    = 1'b0;
    run_idx    = e_reg;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    time_next  = time_counter;
    load_latch = 1'b0;
    walk_step  = 1'b0;
    res_push   = 1'b0;
    res.status         = dltq_pkg::ST_OK;
    res.new_handle     = '0;
    res.expired_valid  = 1'b0;
    res.expired_handle = '0;
    res.free_count     = time_counter;
    res.last           = 1'b1;

    unique case (state)
      dltq_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      dltq_pkg::S_TICK: begin
        rd_addr  = head;
        unit_b   = -{{(AW-dltq_pkg::PERIOD_W){1'b0}}, period};
        delta_wa = head;
        res.free_count = time_counter + {{(dltq_pkg::TIME_W-dltq_pkg::PERIOD_W){1'b0}}, period};
        if (slot_free) begin
          delta_we  = (count != '0);
          time_next = res.free_count;
          res_push  = 1'b1;
        end
      end
      dltq_pkg::S_LOAD: begin
        rd_addr = e_reg;
        if (load_ok) begin
          load_latch = 1'b1;
        end else begin
          res_push = slot_free;
          if (op_reg == dltq_pkg::OP_CANCEL) res.status = dltq_pkg::ST_NOT_RUNNING;
        end
      end
      dltq_pkg::S_REMOVE: begin
        // Fold the leaving entry's delta into its successor and unlink it.
        rd_addr  = n_reg;
        delta_wa = n_reg;
        next_wa  = p_reg;
        next_wd  = n_reg;
        prev_wa  = n_reg;
        prev_wd  = p_reg;
        if (op_reg == dltq_pkg::OP_POLL) begin
          res.expired_valid  = 1'b1;
          res.expired_handle = e_reg;
          res.last           = !poll_more;
        end
        if (slot_free) begin
          delta_we = has_next;
          if (has_prev && has_next) begin
            next_we = 1'b1;
            prev_we = 1'b1;
          end else if (has_next) begin
            head_next = n_reg;
          end else if (has_prev) begin
            tail_next = p_reg;
          end
          run_clr    = 1'b1;
          count_next = count - 1'b1;
          res_push   = 1'b1;
        end
      end
      dltq_pkg::S_WALK: begin
        rd_addr = pos;
        unit_a  = absum;
        unit_b  = sext_delta(delta_rd);
        if (full) begin
          res.status = dltq_pkg::ST_FULL;
          res_push   = slot_free;
        end else if (walk_i != count) begin
          walk_step = 1'b1;
        end
      end
      dltq_pkg::S_LINK: begin
        // New entry goes in front of pos: its delta is measured from pos's predecessor.
        rd_addr  = pos;
        unit_a   = t_ext;
        unit_b   = -prev_absum;
        delta_we = 1'b1;
        delta_wa = nw;
        next_wa  = prev_rd;
        next_wd  = nw;
        prev_wa  = nw;
        prev_wd  = prev_rd;
        if (pos == head) begin
          head_next = nw;
        end else begin
          next_we = 1'b1;
          prev_we = 1'b1;
        end
      end
      dltq_pkg::S_SPLIT: begin
        unit_a         = absum;
        unit_b         = -t_ext;
        delta_wa       = pos;
        next_wa        = nw;
        next_wd        = pos;
        prev_wa        = pos;
        prev_wd        = nw;
        run_idx        = nw;
        res.new_handle = nw;
        if (slot_free) begin
          delta_we   = 1'b1;
          next_we    = 1'b1;
          prev_we    = 1'b1;
          run_set    = 1'b1;
          count_next = count + 1'b1;
          res_push   = 1'b1;
        end
      end
      dltq_pkg::S_APPEND: begin
        unit_a         = t_ext;
        unit_b         = -absum;
        delta_wa       = nw;
        next_wa        = tail;
        next_wd        = nw;
        prev_wa        = nw;
        prev_wd        = tail;
        run_idx        = nw;
        res.new_handle = nw;
        if (slot_free) begin
          delta_we = 1'b1;
          if (count == '0) begin
            head_next = nw;
          end else begin
            next_we = 1'b1;
            prev_we = 1'b1;
          end
          tail_next  = nw;
          run_set    = 1'b1;
          count_next = count + 1'b1;
          res_push   = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dltq_pkg::S_IDLE;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      time_counter <= '0;
      running      <= '0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      tail         <= tail_next;
      count        <= count_next;
      time_counter <= time_next;
      if (run_set) running[run_idx] <= 1'b1;
      if (run_clr) running[run_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (delta_we) delta_mem[delta_wa] <= unit_sat;
    if (next_we)  next_mem[next_wa]   <= next_wd;
    if (prev_we)  prev_mem[prev_wa]   <= prev_wd;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg <= dltq_pkg::op_t'(op);
      t_reg  <= delay_ms;
      e_reg  <= (dltq_pkg::op_t'(op) == dltq_pkg::OP_POLL) ? head : handle;
      k      <= '0;
      absum  <= '0;
      pos    <= head;
      walk_i <= '0;
      nw     <= free_idx;
      full   <= &running;
    end
    if (load_latch) begin
      d_cur <= delta_rd;
      n_reg <= next_rd;
      p_reg <= prev_rd;
    end
    if (state == dltq_pkg::S_REMOVE && slot_free && poll_more) begin
      e_reg <= n_reg;
      k     <= k + 1'b1;
    end
    if (walk_step) begin
      prev_absum <= absum;
      absum      <= unit_sum;
      if (!walk_hit) begin
        pos    <= next_rd;
        walk_i <= walk_i + 1'b1;
      end
    end
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == CW'($countones(running)))
    else $error("running count out of step with running flags");

  a_remove_running: assert property (@(posedge clk) disable iff (rst)
    state == dltq_pkg::S_REMOVE |-> running[e_reg])
    else $error("removing an entry that is not running");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dltq_pkg::S_WALK && !full) |-> (walk_i <= count))
    else $error("list walk ran past the running entries");

  a_create_free: assert property (@(posedge clk) disable iff (rst)
    run_set |-> !running[run_idx])
    else $error("create allocated an entry already running");

endmodule

`default_nettype wire

// ===== rtl/core/delta_list_timer_queue.sv =====
// Top level of the delta list timer queue: configuration register, output register
// and the sequencer. Depends on dltq_pkg and dltq_seq.
`default_nettype none

// The block keeps up to 16 timers in a sorted delta list and takes one command word
// at a time on the input channel: tick, create, cancel or poll. in_ready is high only
// while the sequencer is idle; after a word is accepted the block works on it alone.
// The sequencer steps through its states per word: tick, TICK; cancel, LOAD and
// REMOVE (LOAD alone when the handle is not running); create, WALK over the running
// entries up to the first one due after the new deadline, then LINK and SPLIT, or
// APPEND when it goes at the tail, or WALK alone when the pool is full; poll, LOAD
// alone when nothing has expired, else LOAD and REMOVE per expired entry, up to 16.
// The list walk visits one entry a cycle through a single read port on the entry
// stores and one shared saturating adder. Each word gives one result word, except a
// poll that expires entries, which gives one result per expired entry with last on
// the final one. A result waits in the output register while the next command word
// is accepted; the sequencer holds each step that pushes a result while that
// register is still occupied. clock_period is written over the configuration
// channel, which is always ready; write it only while the block is idle. There is
// no clearing pass after reset: the delta and link stores are only read for running
// entries.
module delta_list_timer_queue (
  input  wire         clk,
  input  wire         rst,

  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  op,
  input  wire  [30:0] delay_ms,
  input  wire  [3:0]  handle,

  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  status,
  output logic [3:0]  new_handle,
  output logic        expired_valid,
  output logic [3:0]  expired_handle,
  output logic [31:0] free_count,
  output logic        last,

  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [15:0] cfg_data
);

  logic [dltq_pkg::PERIOD_W-1:0] clock_period;
  logic                          slot_free;
  logic                          res_push;
  dltq_pkg::res_t                res;
  dltq_pkg::res_t                out_reg;

  // The output register is free when empty or when its word leaves this cycle.
  assign slot_free = !out_valid || out_ready;
  assign cfg_ready = 1'b1;

  dltq_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .delay_ms  (delay_ms),
    .handle    (handle),
    .period    (clock_period),
    .slot_free (slot_free),
    .res_push  (res_push),
    .res       (res)
  );

  // Hold the configuration register; reset to the default period.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_period <= dltq_pkg::PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      clock_period <= cfg_data;
    end
  end

  // Output register: load on push, drop the valid flag once the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) out_reg <= res;
  end

  assign status         = out_reg.status;
  assign new_handle     = out_reg.new_handle;
  assign expired_valid  = out_reg.expired_valid;
  assign expired_handle = out_reg.expired_handle;
  assign free_count     = out_reg.free_count;
  assign last           = out_reg.last;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("command accepted while previous one still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_reg)))
    else $error("result word changed while waiting");

  a_push_needs_slot: assert property (@(posedge clk) disable iff (rst)
    res_push |-> slot_free)
    else $error("result pushed into an occupied output register");

endmodule

`default_nettype wire

// ===== verif/dltq_checker.sv =====
// Checker for the delta list timer queue: watches the command, result and config channels,
// keeps its own copy of the timer list and compares every result word field by field.
// Depends on dltq_pkg for the command, status and result types and its constants.
module dltq_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [1:0]  op,
  input  wire  [30:0] delay_ms,
  input  wire  [3:0]  handle,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [1:0]  status,
  input  wire  [3:0]  new_handle,
  input  wire         expired_valid,
  input  wire  [3:0]  expired_handle,
  input  wire  [31:0] free_count,
  input  wire         last,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);
  import dltq_pkg::*;

  localparam longint DELTA_MAX = 64'sd2147483647;
  localparam longint DELTA_MIN = -64'sd2147483647 - 64'sd1;

  // Shadow timer list.
  logic signed [31:0] tmr_delta [NUM_TIMERS];
  logic [3:0]         tmr_next  [NUM_TIMERS];
  logic [3:0]         tmr_prev  [NUM_TIMERS];
  logic               tmr_run   [NUM_TIMERS];
  logic [3:0]         head_idx;
  logic [3:0]         tail_idx;
  int                 run_count;
  logic [31:0]        now_ms;
  logic [15:0]        tick_ms;

  res_t due_results [$];

  initial errors = 0;

  function automatic logic signed [31:0] clamp_delta(longint x);
    if (x > DELTA_MAX) return 32'sh7fffffff;
    if (x < DELTA_MIN) return 32'sh80000000;
    return x[31:0];
  endfunction

  task automatic add_result(status_t st, logic [3:0] nh, logic ev, logic [3:0] eh,
                            logic lst);
    res_t r;
    r.status         = st;
    r.new_handle     = nh;
    r.expired_valid  = ev;
    r.expired_handle = eh;
    r.free_count     = now_ms;
    r.last           = lst;
    due_results.push_back(r);
  endtask

  // Unlink a running entry and fold its delta into the successor.
  task automatic unlink_timer(logic [3:0] e);
    logic       has_nx;
    logic       has_pv;
    logic [3:0] nx;
    logic [3:0] pv;
    has_nx = (e != tail_idx);
    has_pv = (e != head_idx);
    nx = tmr_next[e];
    pv = tmr_prev[e];
    if (has_nx)
      tmr_delta[nx] = clamp_delta(longint'(tmr_delta[nx]) + longint'(tmr_delta[e]));
    if (has_pv && has_nx) begin
      tmr_next[pv] = nx;
      tmr_prev[nx] = pv;
    end else if (has_nx) begin
      head_idx = nx;
    end else if (has_pv) begin
      tail_idx = pv;
    end
    tmr_run[e] = 1'b0;
    if (run_count > 0) run_count--;
  endtask

  task automatic insert_timer(logic [30:0] dly);
    int         slot;
    longint     due;
    longint     absum;
    logic       found;
    logic [3:0] pos;
    logic [3:0] nw;
    logic [3:0] pv;
    slot = NUM_TIMERS;
    for (int i = NUM_TIMERS - 1; i >= 0; i--)
      if (!tmr_run[i]) slot = i;
    if (slot >= NUM_TIMERS) begin
      add_result(ST_FULL, 4'd0, 1'b0, 4'd0, 1'b1);
      return;
    end
    nw    = slot[3:0];
    due   = longint'(dly);
    absum = 0;
    found = 1'b0;
    pos   = head_idx;
    for (int i = 0; i < run_count && i < NUM_TIMERS && !found; i++) begin
      absum += longint'(tmr_delta[pos]);
      if (due < absum) found = 1'b1;
      else pos = tmr_next[pos];
    end
    if (found) begin
      tmr_delta[nw]  = clamp_delta(due - (absum - longint'(tmr_delta[pos])));
      tmr_delta[pos] = clamp_delta(absum - due);
      if (pos == head_idx) begin
        head_idx = nw;
      end else begin
        pv = tmr_prev[pos];
        tmr_next[pv] = nw;
        tmr_prev[nw] = pv;
      end
      tmr_next[nw]  = pos;
      tmr_prev[pos] = nw;
    end else begin
      tmr_delta[nw] = clamp_delta(due - absum);
      if (run_count == 0) begin
        head_idx = nw;
      end else begin
        tmr_next[tail_idx] = nw;
        tmr_prev[nw] = tail_idx;
      end
      tail_idx = nw;
    end
    tmr_run[nw] = 1'b1;
    run_count++;
    add_result(ST_OK, nw, 1'b0, 4'd0, 1'b1);
  endtask

  task automatic apply_command(op_t o, logic [30:0] dly, logic [3:0] h);
    int         hits;
    logic [3:0] e;
    res_t       tail_res;
    case (o)
      OP_TICK: begin
        if (run_count > 0)
          tmr_delta[head_idx] = clamp_delta(longint'(tmr_delta[head_idx]) - longint'(tick_ms));
        now_ms = now_ms + 32'(tick_ms);
        add_result(ST_OK, 4'd0, 1'b0, 4'd0, 1'b1);
      end
      OP_CREATE: insert_timer(dly);
      OP_CANCEL: begin
        if (!tmr_run[h]) begin
          add_result(ST_NOT_RUNNING, 4'd0, 1'b0, 4'd0, 1'b1);
        end else begin
          unlink_timer(h);
          add_result(ST_OK, 4'd0, 1'b0, 4'd0, 1'b1);
        end
      end
      default: begin
        hits = 0;
        while (hits < MAX_RESULTS && run_count > 0 && tmr_delta[head_idx] <= 0) begin
          e = head_idx;
          unlink_timer(e);
          add_result(ST_OK, 4'd0, 1'b1, e, 1'b0);
          hits++;
        end
        if (hits == 0) begin
          add_result(ST_OK, 4'd0, 1'b0, 4'd0, 1'b1);
        end else begin
          tail_res = due_results.pop_back();
          tail_res.last = 1'b1;
          due_results.push_back(tail_res);
        end
      end
    endcase
  endtask

  task automatic report(string field, longint want, longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  task automatic check_word();
    res_t want;
    if (due_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result word, expected none, got status %0d handle %0d",
               $time, status, expired_handle);
      return;
    end
    want = due_results.pop_front();
    if (want.status != status)                 report("status", want.status, status);
    if (want.new_handle != new_handle)         report("new_handle", want.new_handle, new_handle);
    if (want.expired_valid != expired_valid)
      report("expired_valid", want.expired_valid, expired_valid);
    if (want.expired_handle != expired_handle)
      report("expired_handle", want.expired_handle, expired_handle);
    if (want.free_count != free_count)         report("free_count", want.free_count, free_count);
    if (want.last != last)                     report("last", want.last, last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) tmr_run[i] = 1'b0;
      head_idx  = '0;
      tail_idx  = '0;
      run_count = 0;
      now_ms    = '0;
      tick_ms   = PERIOD_RESET;
      due_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && out_ready) check_word();
      if (cfg_valid && cfg_ready) tick_ms = cfg_data;
      if (in_valid && in_ready) apply_command(op_t'(op), delay_ms, handle);
      outstanding <= due_results.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the delta list timer queue: clock, reset, command and config stimulus,
// result back-pressure and the verdict. Depends on dltq_pkg, dltq_checker and the block.
module tb_top;
  import dltq_pkg::*;

  // Generous cycle budget; a normal run needs a small fraction of it.
  localparam int CYCLE_LIMIT  = 1000000;
  // Cycles to let the sequencer settle after its last result word.
  localparam int SETTLE       = 40;
  localparam int PHASE_WORDS  = 78;

  logic        clk;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  op_t         cmd_op = OP_TICK;
  logic [30:0] cmd_delay = '0;
  logic [3:0]  cmd_handle = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  res_status;
  logic [3:0]  res_new_handle;
  logic        res_expired_valid;
  logic [3:0]  res_expired_handle;
  logic [31:0] res_free_count;
  logic        res_last;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int          errors;
  int          outstanding;
  int          cycle_count = 0;
  int          stall_left = 0;
  // When set, neither side idles: back-to-back words on both channels.
  logic        quiet = 1'b0;
  logic [15:0] cur_period = PERIOD_RESET;

  delta_list_timer_queue u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (cmd_op),
    .delay_ms       (cmd_delay),
    .handle         (cmd_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (res_status),
    .new_handle     (res_new_handle),
    .expired_valid  (res_expired_valid),
    .expired_handle (res_expired_handle),
    .free_count     (res_free_count),
    .last           (res_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  dltq_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (cmd_op),
    .delay_ms       (cmd_delay),
    .handle         (cmd_handle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (res_status),
    .new_handle     (res_new_handle),
    .expired_valid  (res_expired_valid),
    .expired_handle (res_expired_handle),
    .free_count     (res_free_count),
    .last           (res_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: after each accepted word, draw a random stall and drop ready for
  // its length unless it is zero. Ready only falls right after an acceptance.
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_ready) begin
      if (out_valid) begin
        draw = quiet ? 0 : $urandom_range(0, 16);
        if (draw != 0) begin
          out_ready  <= 1'b0;
          stall_left <= draw;
        end
      end
    end else if (stall_left <= 1) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Send one command word. Valid stays high across back-to-back words, so
  // lower it only when a gap is drawn; the payload changes at the acceptance edge.
  task automatic send_word(op_t o, logic [30:0] d, logic [3:0] h);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd_op     <= o;
    cmd_delay  <= d;
    cmd_handle <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off the command channel until every expected result word is back,
  // then let the sequencer finish its last step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write clock_period; only called with the block idle.
  task automatic write_period(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    cur_period <= v;
  endtask

  // Mostly short delays around the tick period so timers actually expire;
  // sometimes zero, the maximum, or any 31-bit value.
  function automatic logic [30:0] pick_delay(logic [15:0] per);
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 15);
    span = (per == 0) ? 32'd8 : 6 * per + 1;
    if (r == 0)     return 31'h7fffffff;
    else if (r < 3) return 31'($urandom);
    else if (r < 5) return '0;
    else            return 31'($urandom_range(0, span));
  endfunction

  task automatic random_phase(int words);
    int unsigned pick;
    for (int k = 0; k < words; k++) begin
      // Flip between idling and back-to-back stretches now and then.
      if ($urandom_range(0, 23) == 0) quiet = !quiet;
      // Pause once mid-phase until every expected result word is back.
      if (k == words / 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 38)
        send_word(OP_CREATE, pick_delay(cur_period), 4'($urandom));
      else if (pick < 65)
        send_word(OP_TICK, 31'($urandom), 4'($urandom));
      else if (pick < 85)
        send_word(OP_POLL, 31'($urandom), 4'($urandom));
      else
        send_word(OP_CANCEL, 31'($urandom), 4'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, ordering with equal deadlines, cancels, a full pool
    // and a poll that expires almost every entry at once.
    send_word(OP_POLL, '0, '0);
    send_word(OP_TICK, '0, '0);
    send_word(OP_CANCEL, '0, 4'hf);
    send_word(OP_CREATE, '0, '0);
    send_word(OP_CREATE, 31'h7fffffff, '0);
    send_word(OP_CREATE, 31'd500, '0);
    send_word(OP_CREATE, 31'd500, '0);
    send_word(OP_CANCEL, '0, 4'd2);
    send_word(OP_CANCEL, '0, 4'd2);
    for (int i = 0; i < 14; i++)
      send_word(OP_CREATE, '0, '0);
    send_word(OP_TICK, '0, '0);
    send_word(OP_POLL, '0, '0);
    drain();

    // Random phases under a range of tick periods, extremes included.
    random_phase(PHASE_WORDS);
    write_period(16'd1);
    random_phase(PHASE_WORDS);
    write_period(16'hffff);
    random_phase(PHASE_WORDS);
    write_period(16'd0);
    random_phase(PHASE_WORDS);
    write_period(16'($urandom_range(1, 65535)));
    random_phase(PHASE_WORDS);
    write_period(16'd1000);
    random_phase(PHASE_WORDS);

    if (errors == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
